### sv/tll_pkg.sv
// shared types and constants for the level-order leaf lister
// no dependencies; used by tree_leaf_lister_level_order
package tll_pkg;

  // node index as it travels on the streams and in the walk queue
  localparam int IDX_W = 4;

  // one row of child links: left index, has_left, right index, has_right
  localparam int LINK_W        = 10;
  localparam int LEFT_LSB      = 0;
  localparam int HAS_LEFT_BIT  = 4;
  localparam int RIGHT_LSB     = 5;
  localparam int HAS_RIGHT_BIT = 9;

  // stream data widths, padded to whole bytes
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  // listing stops after this many leaves
  localparam int LEAF_LIMIT = 8;
  localparam int LEAF_CNT_W = 4;

  typedef enum logic [7:0] {
    ST_LOAD   = 8'b0000_0001,
    ST_SEARCH = 8'b0000_0010,
    ST_POP    = 8'b0000_0100,
    ST_LINK   = 8'b0000_1000,
    ST_DECIDE = 8'b0001_0000,
    ST_PUSHL  = 8'b0010_0000,
    ST_PUSHR  = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_t;

endpackage

### sv/tree_leaf_lister_level_order.sv
// binary tree leaf lister: loads node rows, then lists leaves breadth first
// depends on tll_pkg and tll_ram
// rate: one row beat per cycle while loading; after the last row the root
// scan checks indices in turn (up to MAX_NODES + 1 of them), then each node
// popped passes through queue read, link read, decide and a left and a right
// push slot (at most one access per ram port a cycle), and the walk closes
// with a final empty check and the release of the last leaf; a full output
// register stalls the walk. reset (rst_n low, synchronous) empties the load,
// the queue pointers and the output register.
module tree_leaf_lister_level_order #(
  parameter int MAX_NODES   = 16,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // node rows
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [3:0] left_index, [4] has_left, [8:5] right_index, [9] has_right
  input  logic [tll_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                               in_tlast,   // last_row
  // leaves
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [3:0] leaf_index
  output logic [tll_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tlast   // last_leaf
);

  // table address, row counter, queue pointer widths
  localparam int NW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int RCW = $clog2(MAX_NODES + 1);
  localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam int IW = tll_pkg::IDX_W;

  tll_pkg::state_t state_r, state_nxt;

  logic [RCW-1:0]       row_count_r, row_count_nxt;
  logic [MAX_NODES-1:0] is_child_r, is_child_nxt;
  logic [RCW-1:0]       scan_r, scan_nxt;      // root scan index
  logic [RCW-1:0]       visits_r, visits_nxt;
  logic [tll_pkg::LEAF_CNT_W-1:0] leaf_cnt_r, leaf_cnt_nxt;
  logic [QW-1:0]        head_r, head_nxt;
  logic [QW-1:0]        tail_r, tail_nxt;

  // node being visited and its decoded links
  logic [IW-1:0] node_r, node_nxt;
  logic          link_ok_r, link_ok_nxt;      // node is a loaded row
  logic [IW-1:0] li_r, li_nxt, ri_r, ri_nxt;
  logic          lv_r, lv_nxt, rv_r, rv_nxt;

  // one leaf held back so the final one can carry the last flag
  logic          hold_vld_r, hold_vld_nxt;
  logic [IW-1:0] hold_idx_r, hold_idx_nxt;

  // output register
  logic          out_vld_r, out_vld_nxt;
  logic [IW-1:0] out_leaf_r, out_leaf_nxt;
  logic          out_last_r, out_last_nxt;

  // ram ports
  logic                      lk_wr_en, lk_rd_en;
  logic [NW-1:0]             lk_wr_addr, lk_rd_addr;
  logic [tll_pkg::LINK_W-1:0] lk_wr_data, lk_rd_data;
  logic                      q_wr_en, q_rd_en;
  logic [QW-1:0]             q_wr_addr, q_rd_addr;
  logic [IW-1:0]             q_wr_data, q_rd_data;

  // decode helpers
  logic [tll_pkg::LINK_W-1:0] links;
  logic [IW-1:0]              dec_li, dec_ri;
  logic                       dec_lv, dec_rv, dec_leaf;
  logic [IW-1:0]              row_l, row_r;
  logic                       row_hl, row_hr;
  logic [QW-1:0]              tail_inc;
  logic                       q_full, out_free, walk_more;

  tll_ram #(.WIDTH(tll_pkg::LINK_W), .DEPTH(MAX_NODES)) u_links (
    .clk     (clk),
    .wr_en   (lk_wr_en),
    .wr_addr (lk_wr_addr),
    .wr_data (lk_wr_data),
    .rd_en   (lk_rd_en),
    .rd_addr (lk_rd_addr),
    .rd_data (lk_rd_data)
  );

  tll_ram #(.WIDTH(IW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .wr_en   (q_wr_en),
    .wr_addr (q_wr_addr),
    .wr_data (q_wr_data),
    .rd_en   (q_rd_en),
    .rd_addr (q_rd_addr),
    .rd_data (q_rd_data)
  );

  assign in_tready  = (state_r == tll_pkg::ST_LOAD);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(tll_pkg::OUT_TDATA_W - IW){1'b0}}, out_leaf_r};
  assign out_tlast  = out_last_r;

  // incoming row fields
  assign row_l  = in_tdata[tll_pkg::LEFT_LSB +: IW];
  assign row_hl = in_tdata[tll_pkg::HAS_LEFT_BIT];
  assign row_r  = in_tdata[tll_pkg::RIGHT_LSB +: IW];
  assign row_hr = in_tdata[tll_pkg::HAS_RIGHT_BIT];

  // circular queue keeps one slot empty
  assign tail_inc = (tail_r == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + QW'(1);
  assign q_full   = (tail_inc == head_r);

  assign out_free = !out_vld_r || out_tready;

  // links of the visited node; rows never loaded read as no children
  assign links  = link_ok_r ? lk_rd_data : '0;
  assign dec_li = links[tll_pkg::LEFT_LSB +: IW];
  assign dec_ri = links[tll_pkg::RIGHT_LSB +: IW];
  // a child at or beyond the row count is treated as absent
  assign dec_lv = links[tll_pkg::HAS_LEFT_BIT] && (32'(dec_li) < 32'(row_count_r));
  assign dec_rv = links[tll_pkg::HAS_RIGHT_BIT] && (32'(dec_ri) < 32'(row_count_r));
  assign dec_leaf = !dec_lv && !dec_rv;

  // walk goes on while the queue has entries and no limit is reached
  assign walk_more = (head_r != tail_r) && (32'(visits_r) < MAX_NODES)
                   && (32'(leaf_cnt_r) < tll_pkg::LEAF_LIMIT);

  always_comb begin
    state_nxt     = state_r;
    row_count_nxt = row_count_r;
    is_child_nxt  = is_child_r;
    scan_nxt      = scan_r;
    visits_nxt    = visits_r;
    leaf_cnt_nxt  = leaf_cnt_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    node_nxt      = node_r;
    link_ok_nxt   = link_ok_r;
    li_nxt        = li_r;
    ri_nxt        = ri_r;
    lv_nxt        = lv_r;
    rv_nxt        = rv_r;
    hold_vld_nxt  = hold_vld_r;
    hold_idx_nxt  = hold_idx_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_leaf_nxt  = out_leaf_r;
    out_last_nxt  = out_last_r;

    lk_wr_en   = 1'b0;
    lk_wr_addr = NW'(row_count_r);
    lk_wr_data = in_tdata[tll_pkg::LINK_W-1:0];
    lk_rd_en   = 1'b0;
    lk_rd_addr = NW'(q_rd_data);
    q_wr_en    = 1'b0;
    q_wr_addr  = tail_r;
    q_wr_data  = li_r;
    q_rd_en    = 1'b0;
    q_rd_addr  = head_r;

    unique case (state_r)
      tll_pkg::ST_LOAD: begin
        if (in_tvalid) begin
          // rows past capacity are dropped, but the last flag still counts
          if (32'(row_count_r) < MAX_NODES) begin
            lk_wr_en      = 1'b1;
            row_count_nxt = row_count_r + RCW'(1);
            for (int i = 0; i < MAX_NODES; i++) begin
              if ((row_hl && 32'(row_l) == i) || (row_hr && 32'(row_r) == i)) begin
                is_child_nxt[i] = 1'b1;
              end
            end
          end
          if (in_tlast) begin
            scan_nxt  = '0;
            state_nxt = tll_pkg::ST_SEARCH;
          end
        end
      end

      tll_pkg::ST_SEARCH: begin
        if (32'(scan_r) >= 32'(row_count_r)) begin
          // every node is someone's child: nothing to list
          row_count_nxt = '0;
          is_child_nxt  = '0;
          state_nxt     = tll_pkg::ST_LOAD;
        end else if (!is_child_r[NW'(scan_r)]) begin
          // root found, seed the queue
          if (!q_full) begin
            q_wr_en   = 1'b1;
            q_wr_data = IW'(scan_r);
            tail_nxt  = tail_inc;
          end
          visits_nxt   = '0;
          leaf_cnt_nxt = '0;
          state_nxt    = tll_pkg::ST_POP;
        end else begin
          scan_nxt = scan_r + RCW'(1);
        end
      end

      tll_pkg::ST_POP: begin
        if (walk_more) begin
          q_rd_en    = 1'b1;
          head_nxt   = (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r + QW'(1);
          visits_nxt = visits_r + RCW'(1);
          state_nxt  = tll_pkg::ST_LINK;
        end else begin
          state_nxt = tll_pkg::ST_DONE;
        end
      end

      tll_pkg::ST_LINK: begin
        node_nxt    = q_rd_data;
        link_ok_nxt = (32'(q_rd_data) < 32'(row_count_r)) && (32'(q_rd_data) < MAX_NODES);
        lk_rd_en    = link_ok_nxt;
        state_nxt   = tll_pkg::ST_DECIDE;
      end

      tll_pkg::ST_DECIDE: begin
        // a new leaf pushes the held one out, so it needs a free output slot
        if (!(dec_leaf && hold_vld_r && !out_free)) begin
          if (dec_leaf) begin
            if (hold_vld_r) begin
              out_vld_nxt  = 1'b1;
              out_leaf_nxt = hold_idx_r;
              out_last_nxt = 1'b0;
            end
            hold_vld_nxt = 1'b1;
            hold_idx_nxt = node_r;
            leaf_cnt_nxt = leaf_cnt_r + tll_pkg::LEAF_CNT_W'(1);
          end
          li_nxt    = dec_li;
          ri_nxt    = dec_ri;
          lv_nxt    = dec_lv;
          rv_nxt    = dec_rv;
          state_nxt = tll_pkg::ST_PUSHL;
        end
      end

      tll_pkg::ST_PUSHL: begin
        if (lv_r && !q_full) begin
          q_wr_en   = 1'b1;
          q_wr_data = li_r;
          tail_nxt  = tail_inc;
        end
        state_nxt = tll_pkg::ST_PUSHR;
      end

      tll_pkg::ST_PUSHR: begin
        if (rv_r && !q_full) begin
          q_wr_en   = 1'b1;
          q_wr_data = ri_r;
          tail_nxt  = tail_inc;
        end
        state_nxt = tll_pkg::ST_POP;
      end

      tll_pkg::ST_DONE: begin
        // release the held leaf as the last one, then clear the load
        if (!hold_vld_r || out_free) begin
          if (hold_vld_r) begin
            out_vld_nxt  = 1'b1;
            out_leaf_nxt = hold_idx_r;
            out_last_nxt = 1'b1;
          end
          hold_vld_nxt  = 1'b0;
          row_count_nxt = '0;
          is_child_nxt  = '0;
          head_nxt      = '0;
          tail_nxt      = '0;
          state_nxt     = tll_pkg::ST_LOAD;
        end
      end

      default: begin
        state_nxt = tll_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tll_pkg::ST_LOAD;
      row_count_r <= '0;
      is_child_r  <= '0;
      scan_r      <= '0;
      visits_r    <= '0;
      leaf_cnt_r  <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      hold_vld_r  <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_count_r <= row_count_nxt;
      is_child_r  <= is_child_nxt;
      scan_r      <= scan_nxt;
      visits_r    <= visits_nxt;
      leaf_cnt_r  <= leaf_cnt_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      hold_vld_r  <= hold_vld_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    node_r     <= node_nxt;
    link_ok_r  <= link_ok_nxt;
    li_r       <= li_nxt;
    ri_r       <= ri_nxt;
    lv_r       <= lv_nxt;
    rv_r       <= rv_nxt;
    hold_idx_r <= hold_idx_nxt;
    out_leaf_r <= out_leaf_nxt;
    out_last_r <= out_last_nxt;
  end

  // leaf count never runs past the listing limit
  a_leaf_limit: assert property (@(posedge clk) disable iff (!rst_n)
    32'(leaf_cnt_r) <= tll_pkg::LEAF_LIMIT)
    else $error("leaf count beyond limit");

  // a held leaf only exists while a walk is in progress
  a_hold_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    hold_vld_r |-> !(state_r == tll_pkg::ST_LOAD || state_r == tll_pkg::ST_SEARCH))
    else $error("held leaf outside walk");

  // queue is empty and rewound whenever rows are being loaded
  a_queue_rewound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tll_pkg::ST_LOAD) |-> (head_r == '0 && tail_r == '0))
    else $error("queue not rewound during load");

endmodule

### sv/tll_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies; instanced for the link table and the walk queue
module tll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sim/tll_leaf_checker.sv
// watches both streams of the level-order leaf lister, predicts its leaves
// and compares them beat by beat; depends on tll_pkg
module tll_leaf_checker #(
  parameter int MAX_NODES   = 16,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // [3:0] left_index, [4] has_left, [8:5] right_index, [9] has_right
  input  logic [tll_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tlast,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // [3:0] leaf_index
  input  logic [tll_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            out_tlast,
  output int                              fail_count,
  output int                              leaves_pending
);

  typedef struct packed {
    logic [tll_pkg::IDX_W-1:0] idx;
    logic                      last;
  } leaf_t;

  // predicted tree load
  logic [tll_pkg::LINK_W-1:0] row_links [MAX_NODES];
  bit                         named_child [MAX_NODES];
  int unsigned                rows_loaded;

  // breadth-first queue, one slot always kept free
  logic [tll_pkg::IDX_W-1:0]  bfs_q [QUEUE_DEPTH];
  int unsigned                bfs_head;
  int unsigned                bfs_tail;

  leaf_t                      leaves_due [$];

  function automatic void flag_mismatch(string what, int want_v, int got_v);
    fail_count++;
    // want_v of -1 means no leaf was due
    if (fail_count <= 10)
      $display("leaf mismatch on %s: expected %0d, got %0d", what, want_v, got_v);
  endfunction

  function automatic void bfs_push(int unsigned node);
    int unsigned nxt;
    nxt = (bfs_tail + 1) % QUEUE_DEPTH;
    if (nxt != bfs_head) begin
      bfs_q[bfs_tail] = node[tll_pkg::IDX_W-1:0];
      bfs_tail = nxt;
    end
  endfunction

  // store one row; on the last row find the root and list leaves breadth first
  function automatic void load_row(logic [tll_pkg::IN_TDATA_W-1:0] d, logic last_row);
    int unsigned                root;
    int unsigned                visits;
    int unsigned                node;
    int                         found;
    logic [tll_pkg::LINK_W-1:0] lk;
    bit                         go_left;
    bit                         go_right;
    bit                         have_pend;
    logic [tll_pkg::IDX_W-1:0]  pend;
    if (rows_loaded < MAX_NODES) begin
      row_links[rows_loaded] = d[tll_pkg::LINK_W-1:0];
      if (d[tll_pkg::HAS_LEFT_BIT] && d[tll_pkg::LEFT_LSB +: tll_pkg::IDX_W] < MAX_NODES)
        named_child[d[tll_pkg::LEFT_LSB +: tll_pkg::IDX_W]] = 1'b1;
      if (d[tll_pkg::HAS_RIGHT_BIT] && d[tll_pkg::RIGHT_LSB +: tll_pkg::IDX_W] < MAX_NODES)
        named_child[d[tll_pkg::RIGHT_LSB +: tll_pkg::IDX_W]] = 1'b1;
      rows_loaded++;
    end
    if (!last_row)
      return;
    root = 0;
    while (root < rows_loaded && named_child[root])
      root++;
    if (root < rows_loaded) begin
      bfs_head  = 0;
      bfs_tail  = 0;
      bfs_push(root);
      visits    = 0;
      found     = 0;
      have_pend = 1'b0;
      pend      = '0;
      while (bfs_head != bfs_tail && visits < MAX_NODES && found < tll_pkg::LEAF_LIMIT) begin
        node     = 32'(bfs_q[bfs_head]);
        bfs_head = (bfs_head + 1) % QUEUE_DEPTH;
        visits++;
        lk       = (node < rows_loaded) ? row_links[node] : '0;
        // links that point past the load count as absent
        go_left  = lk[tll_pkg::HAS_LEFT_BIT]
                   && lk[tll_pkg::LEFT_LSB +: tll_pkg::IDX_W] < rows_loaded;
        go_right = lk[tll_pkg::HAS_RIGHT_BIT]
                   && lk[tll_pkg::RIGHT_LSB +: tll_pkg::IDX_W] < rows_loaded;
        if (!go_left && !go_right) begin
          if (have_pend)
            leaves_due.push_back({pend, 1'b0});
          pend      = node[tll_pkg::IDX_W-1:0];
          have_pend = 1'b1;
          found++;
        end
        if (go_left)
          bfs_push(32'(lk[tll_pkg::LEFT_LSB +: tll_pkg::IDX_W]));
        if (go_right)
          bfs_push(32'(lk[tll_pkg::RIGHT_LSB +: tll_pkg::IDX_W]));
      end
      if (have_pend)
        leaves_due.push_back({pend, 1'b1});
    end
    foreach (named_child[i])
      named_child[i] = 1'b0;
    rows_loaded = 0;
  endfunction

  always @(posedge clk) begin
    leaf_t want;
    if (!rst_n) begin
      foreach (named_child[i])
        named_child[i] = 1'b0;
      rows_loaded = 0;
      bfs_head    = 0;
      bfs_tail    = 0;
      leaves_due.delete();
    end else begin
      if (in_tvalid && in_tready)
        load_row(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (leaves_due.size() == 0) begin
          flag_mismatch("unexpected leaf_index", -1,
                        int'(out_tdata[tll_pkg::IDX_W-1:0]));
        end else begin
          want = leaves_due.pop_front();
          if (out_tdata[tll_pkg::IDX_W-1:0] !== want.idx)
            flag_mismatch("leaf_index", int'(want.idx),
                          int'(out_tdata[tll_pkg::IDX_W-1:0]));
          if (out_tlast !== want.last)
            flag_mismatch("last_leaf", int'(want.last), int'(out_tlast));
        end
      end
    end
    leaves_pending = leaves_due.size();
  end

endmodule

### sim/tb_tree_leaf_lister_level_order.sv
// top of the leaf lister bench: clock, reset, row stimulus and output stalls
// depends on tll_pkg, tree_leaf_lister_level_order and tll_leaf_checker
module tb_tree_leaf_lister_level_order;

  localparam int NODES      = 16;
  localparam int RAND_ROWS  = 80;
  localparam int DRAIN_WAIT = 200;      // root scan plus a full walk, with slack
  localparam int HOLD_LEN   = 400;      // long receiver hold-off
  localparam int LIMIT      = 200000;   // cycle budget for the whole run

  logic                            clk;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [tll_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                            in_tlast   = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [tll_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tlast;

  int fail_count;
  int leaves_pending;

  // idling knobs, changed per group of tree loads
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // hold-off request from the stimulus, served once by the receiver process
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  int rows_sent = 0;
  int cycles    = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  tree_leaf_lister_level_order DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  tll_leaf_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .fail_count     (fail_count),
    .leaves_pending (leaves_pending)
  );

  // receiver: a requested hold-off wins, otherwise random stalls
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // one node row beat; random idle cycles before it, then wait for the handshake
  task automatic send_row(logic [tll_pkg::IDX_W-1:0] l, bit hl,
                          logic [tll_pkg::IDX_W-1:0] r, bit hr, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(tll_pkg::IN_TDATA_W - tll_pkg::LINK_W){1'b0}}, hr, r, hl, l};
    in_tlast  <= last;
    do
      @(posedge clk);
    while (!in_tready);
    rows_sent++;
  endtask

  // well-formed tree of n nodes: shuffled numbering, so the root can be any index
  task automatic send_tree(int n);
    int lk [NODES];
    int rk [NODES];
    int order [NODES];
    int p;
    int j;
    int tmp;
    int par;
    for (int i = 0; i < NODES; i++) begin
      lk[i]    = -1;
      rk[i]    = -1;
      order[i] = i;
    end
    for (int i = n - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    // hang each node under an earlier one that still has a free slot
    for (int i = 1; i < n; i++) begin
      p = $urandom_range(i - 1);
      while (lk[order[p]] >= 0 && rk[order[p]] >= 0)
        p = (p + 1) % i;
      par = order[p];
      if (lk[par] < 0 && (rk[par] >= 0 || $urandom_range(1) == 0))
        lk[par] = order[i];
      else
        rk[par] = order[i];
    end
    // unused index fields carry random junk
    for (int i = 0; i < n; i++)
      send_row(tll_pkg::IDX_W'(lk[i] >= 0 ? lk[i] : $urandom_range(15)), lk[i] >= 0,
               tll_pkg::IDX_W'(rk[i] >= 0 ? rk[i] : $urandom_range(15)), rk[i] >= 0,
               i == n - 1);
  endtask

  // arbitrary links: cycles, shared children, no root, far indices
  task automatic send_noise(int n);
    for (int i = 0; i < n; i++)
      send_row(tll_pkg::IDX_W'($urandom_range(15)), 1'($urandom_range(1)),
               tll_pkg::IDX_W'($urandom_range(15)), 1'($urandom_range(1)),
               i == n - 1);
  endtask

  // watchdog
  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_tree_leaf_lister_level_order NOT OK");
    $finish;
  end

  initial begin
    int load_no;
    int pick;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed loads, no idling
    // lone root 0, junk in the unused index fields
    send_row(15, 0, 15, 0, 1);
    // root 1; node 0 points past the load so it lists as a leaf
    send_row(9, 1, 15, 0, 0);
    send_row(0, 1, 2, 1, 0);
    send_row(0, 0, 0, 0, 1);
    // every node named as a child: no root, nothing listed
    send_row(1, 1, 15, 1, 0);
    send_row(0, 1, 0, 0, 1);
    // node 1 points at itself twice: the walk floods the queue, no leaf
    send_row(1, 1, 0, 0, 0);
    send_row(1, 1, 1, 1, 1);
    // full 16-node heap-shaped tree, leaf limit reached on the last leaf;
    // the extra row is past capacity, its mark on node 0 must be ignored
    for (int i = 0; i < NODES; i++)
      send_row(tll_pkg::IDX_W'(2 * i + 1 < NODES ? 2 * i + 1 : 0), 2 * i + 1 < NODES,
               tll_pkg::IDX_W'(2 * i + 2 < NODES ? 2 * i + 2 : 0), 2 * i + 2 < NODES, 0);
    send_row(0, 1, 0, 1, 1);

    // random loads, idling pattern switched every three loads
    load_no = 0;
    while (rows_sent < 25 + RAND_ROWS) begin
      case ((load_no / 3) % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 87;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 87;
        end
        default: begin
          send_idle_pct  = 27;
          recv_stall_pct = 27;
        end
      endcase
      // long hold-off while rows keep coming, so the input backs up
      if (load_no == 1)
        hold_req = 1'b1;
      pick = $urandom_range(99);
      if (pick < 75)
        send_tree($urandom_range(1, 7));
      else if (pick < 85)
        send_tree($urandom_range(8, NODES));
      else if (pick < 95)
        send_noise($urandom_range(1, 6));
      else
        send_noise($urandom_range(NODES + 1, NODES + 4));
      load_no++;
    end
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;

    // let the checker take the last beat, then drain
    @(posedge clk);
    while (leaves_pending != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0 && leaves_pending == 0) begin
      $display("tb_tree_leaf_lister_level_order OK");
    end else begin
      $display("tb_tree_leaf_lister_level_order NOT OK");
    end
    $finish;
  end

endmodule

### files.f
sv/tll_pkg.sv
sv/tll_ram.sv
sv/tree_leaf_lister_level_order.sv
sim/tll_leaf_checker.sv
sim/tb_tree_leaf_lister_level_order.sv
